// File: src/lmps_pkg.sv
package lmps_pkg;

    // Geometry and field widths.
    localparam int COLUMNS_DEFAULT = 8;
    localparam int ROWS            = 8;
    localparam int LEVEL_W         = 8;
    localparam int CYC_W           = 8;
    localparam int LIT_W           = 4;
    localparam int NUM_W           = 5;
    localparam int PROD_W          = 16;
    localparam int BASE_W          = 17;
    localparam int CMP_W           = 23;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_CALIBRATED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PLAIN      = 2'd2;

    // Configuration reset values.
    localparam logic                 CALIBRATE_RESET = 1'b1;
    localparam logic [CYC_W-1:0]     CYCLES_CAL_RESET   = 8'd4;
    localparam logic [CYC_W-1:0]     CYCLES_PLAIN_RESET = 8'd10;

    // Denominators and the plain numerator of the brightness factor.
    localparam logic [NUM_W-1:0] DEN_PLAIN = 5'd1;
    localparam logic [NUM_W-1:0] DEN_CAL   = 5'd10;
    localparam logic [NUM_W-1:0] DEN_LAST  = 5'd20;
    localparam logic [NUM_W-1:0] NUM_PLAIN = 5'd1;

    // Input operations.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef struct packed {
        op_t          operation;
        logic [5:0]   pixel_index;
        logic [7:0]   pixel_level;
    } in_item_t;

    typedef struct packed {
        logic [2:0]   column;
        logic [7:0]   row_drive;
        logic         frame_end;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic pix_write;
        logic tick_start;
        logic mult_en;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_blocked;
    } dp_stat_t;

    // Calibration factor numerator (over 10 or 20) by lit pixel count.
    function automatic logic [NUM_W-1:0] cal_num(input logic [LIT_W-1:0] lit,
                                                 input logic full);
        logic [NUM_W-1:0] n;
        unique case (lit)
            4'd1:    n = full ? 5'd4 : 5'd8;
            4'd2:    n = full ? 5'd5 : 5'd8;
            4'd3:    n = 5'd8;
            4'd4:    n = 5'd9;
            4'd5:    n = 5'd12;
            4'd6:    n = 5'd15;
            4'd7:    n = 5'd20;
            default: n = 5'd10;
        endcase
        return n;
    endfunction

endpackage

// File: src/lmps_ctrl.sv
module lmps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  lmps_pkg::op_t        item_op,
    input  lmps_pkg::dp_stat_t   stat,
    output logic                 item_stall,
    output lmps_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MULT = 3'b010,
        S_EVAL = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Input is taken only while no scan tick is in flight.
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        cmd.pix_write  = accept && (item_op == lmps_pkg::OP_WRITE);
        cmd.tick_start = accept && (item_op == lmps_pkg::OP_TICK);
        cmd.mult_en    = (state_reg == S_MULT);
        cmd.finish     = (state_reg == S_EVAL) && !stat.out_blocked;
    end

    // Next state: a tick walks through multiply and evaluate, then waits on the output.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.tick_start)
                begin
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (cmd.finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/lmps_dp.sv
module lmps_dp #(
    parameter int COLUMNS = lmps_pkg::COLUMNS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lmps_pkg::in_item_t                  item,
    input  lmps_pkg::ctrl_cmd_t                 cmd,
    output lmps_pkg::dp_stat_t                  stat,
    input  logic                                cfg_we,
    input  logic [lmps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lmps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                result_valid,
    input  logic                                result_stall,
    output lmps_pkg::out_item_t                 result
);

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    // Configuration registers.
    logic                          calibrate_reg;
    logic [lmps_pkg::CYC_W-1:0]    cycles_cal_reg;
    logic [lmps_pkg::CYC_W-1:0]    cycles_plain_reg;

    // Scan counters.
    logic [COL_W-1:0]              column_reg;
    logic [COL_W-1:0]              column_next;
    logic [lmps_pkg::CYC_W-1:0]    cycle_reg;
    logic [lmps_pkg::CYC_W-1:0]    cycle_next;

    // Level store and its per-pixel valid bits.
    logic [7:0][7:0]               mem [COLUMNS];
    logic [7:0]                    valid_reg [COLUMNS];
    logic [2:0]                    wr_col;
    logic [2:0]                    wr_row;
    logic                          wr_hit;

    // Tick snapshot, taken when the tick is accepted.
    logic [7:0][7:0]               row_data_reg;
    logic [7:0]                    row_valid_reg;
    logic [COL_W-1:0]              tick_col_reg;
    logic [lmps_pkg::CYC_W-1:0]    tick_cycles_reg;
    logic [lmps_pkg::CYC_W-1:0]    tick_cc_reg;
    logic [lmps_pkg::CYC_W-1:0]    cycles_sel;
    logic [lmps_pkg::CYC_W-1:0]    cycles_eff;
    logic [lmps_pkg::CYC_W-1:0]    cc_eff;

    // Multiply stage.
    logic [lmps_pkg::PROD_W-1:0]   prod_reg [lmps_pkg::ROWS];
    logic [lmps_pkg::PROD_W-1:0]   prod_next [lmps_pkg::ROWS];
    logic [7:0]                    full_reg;
    logic [7:0]                    full_next;
    logic [lmps_pkg::LIT_W-1:0]    lit_reg;
    logic [lmps_pkg::LIT_W-1:0]    lit_next;
    logic [lmps_pkg::NUM_W-1:0]    den_reg;
    logic [lmps_pkg::NUM_W-1:0]    den_next;
    logic [lmps_pkg::BASE_W-1:0]   base_reg;
    logic [lmps_pkg::BASE_W-1:0]   base_next;
    logic [7:0][7:0]               lv;

    // Evaluate stage.
    logic [7:0]                    drive;
    logic [lmps_pkg::CMP_W-1:0]    rhs;
    logic [lmps_pkg::CMP_W-1:0]    lhs [lmps_pkg::ROWS];
    logic [lmps_pkg::NUM_W-1:0]    num [lmps_pkg::ROWS];
    logic                          tick_last;
    logic                          frame_end;
    logic [lmps_pkg::CYC_W:0]      cc_inc;

    // Output register.
    logic                          result_valid_reg;
    logic                          result_valid_next;
    lmps_pkg::out_item_t           result_reg;

    assign stat.out_blocked = result_valid_reg && result_stall;
    assign result_valid     = result_valid_reg;
    assign result           = result_reg;

    // Configuration writes; an unknown index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calibrate_reg    <= lmps_pkg::CALIBRATE_RESET;
            cycles_cal_reg   <= lmps_pkg::CYCLES_CAL_RESET;
            cycles_plain_reg <= lmps_pkg::CYCLES_PLAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lmps_pkg::CFG_CALIBRATE:         calibrate_reg    <= cfg_data[0];
                lmps_pkg::CFG_CYCLES_CALIBRATED: cycles_cal_reg   <= cfg_data;
                lmps_pkg::CFG_CYCLES_PLAIN:      cycles_plain_reg <= cfg_data;
                default:                         ;
            endcase
        end
    end

    // Pixel write address; columns beyond the matrix are ignored.
    assign wr_col = item.pixel_index[5:3];
    assign wr_row = item.pixel_index[2:0];
    assign wr_hit = cmd.pix_write && (32'(wr_col) < COLUMNS);

    // Store: one level written per transfer, one column read per tick.
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[COL_W'(wr_col)][wr_row] <= item.pixel_level;
        end
        if (cmd.tick_start)
        begin
            row_data_reg <= mem[column_reg];
        end
    end

    // Valid bits make unwritten levels read as zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < COLUMNS; c++)
            begin
                valid_reg[c] <= '0;
            end
            row_valid_reg <= '0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg[COL_W'(wr_col)][wr_row] <= 1'b1;
            end
            if (cmd.tick_start)
            begin
                row_valid_reg <= valid_reg[column_reg];
            end
        end
    end

    // Active cycle count and the cycle index as seen by this tick.
    always_comb
    begin
        cycles_sel = calibrate_reg ? cycles_cal_reg : cycles_plain_reg;
        cycles_eff = (cycles_sel == '0) ? 8'd1 : cycles_sel;
        cc_eff     = (cycle_reg >= cycles_eff) ? '0 : cycle_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_start)
        begin
            tick_col_reg    <= column_reg;
            tick_cycles_reg <= cycles_eff;
            tick_cc_reg     <= cc_eff;
        end
    end

    // Multiply stage: cycles times level per row, lit count, factor denominator and threshold base.
    always_comb
    begin
        lit_next = '0;
        for (int r = 0; r < lmps_pkg::ROWS; r++)
        begin
            lv[r]        = row_valid_reg[r] ? row_data_reg[r] : 8'd0;
            prod_next[r] = lmps_pkg::PROD_W'(tick_cycles_reg) * lmps_pkg::PROD_W'(lv[r]);
            full_next[r] = (lv[r] == lmps_pkg::LEVEL_FULL);
            lit_next     = lit_next + lmps_pkg::LIT_W'(lv[r] != 8'd0);
        end
        if (!calibrate_reg)
        begin
            den_next = lmps_pkg::DEN_PLAIN;
        end
        else if ((tick_col_reg == LAST_COL) && (lit_next == 4'd1))
        begin
            den_next = lmps_pkg::DEN_LAST;
        end
        else
        begin
            den_next = lmps_pkg::DEN_CAL;
        end
        base_next = (lmps_pkg::BASE_W'(tick_cc_reg) + 17'd1)
                    * lmps_pkg::BASE_W'(2 * 255);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mult_en)
        begin
            for (int r = 0; r < lmps_pkg::ROWS; r++)
            begin
                prod_reg[r] <= prod_next[r];
            end
            full_reg <= full_next;
            lit_reg  <= lit_next;
            den_reg  <= den_next;
            base_reg <= base_next;
        end
    end

    // Evaluate stage: a row's drive bit is set when 2*C*L*num + 255*den < 2*255*den*(cycle+1),
    // which is the rounded threshold compare without a divider.
    always_comb
    begin
        rhs = lmps_pkg::CMP_W'(base_reg) * lmps_pkg::CMP_W'(den_reg);
        for (int r = 0; r < lmps_pkg::ROWS; r++)
        begin
            num[r]   = calibrate_reg ? lmps_pkg::cal_num(lit_reg, full_reg[r])
                                     : lmps_pkg::NUM_PLAIN;
            lhs[r]   = ((lmps_pkg::CMP_W'(prod_reg[r]) * lmps_pkg::CMP_W'(num[r])) << 1)
                       + lmps_pkg::CMP_W'(den_reg) * lmps_pkg::CMP_W'(lmps_pkg::LEVEL_FULL);
            drive[r] = !(lhs[r] >= rhs);
        end
        tick_last = (tick_col_reg == LAST_COL);
        frame_end = tick_last && (tick_cc_reg == (tick_cycles_reg - 8'd1));
    end

    // Counter advance after each finished tick.
    always_comb
    begin
        cc_inc      = {1'b0, tick_cc_reg} + 9'd1;
        column_next = column_reg;
        cycle_next  = cycle_reg;
        if (cmd.finish)
        begin
            if (tick_last)
            begin
                column_next = '0;
                cycle_next  = (cc_inc >= {1'b0, tick_cycles_reg}) ? '0
                                                                 : cc_inc[lmps_pkg::CYC_W-1:0];
            end
            else
            begin
                column_next = tick_col_reg + COL_W'(1);
                cycle_next  = tick_cc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            cycle_reg  <= '0;
        end
        else
        begin
            column_reg <= column_next;
            cycle_reg  <= cycle_next;
        end
    end

    // Output register: loaded on finish, emptied by a transfer.
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.finish)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.column    <= 3'(tick_col_reg);
            result_reg.row_drive <= drive;
            result_reg.frame_end <= frame_end;
        end
    end

endmodule

// File: src/led_matrix_pwm_scan_top.sv
// Channel  | Signals                                 | Transfer when
// item     | item_valid, item_stall, item            | item_valid && !item_stall
// result   | result_valid, result_stall, result      | result_valid && !result_stall
// config   | cfg_we, cfg_index, cfg_data             | cfg_we
//
// After a pixel write the next item may follow at once.
// A scan tick runs through store read, per-row multiply and threshold compare;
// the compare stage holds until the output register is free.
// The output register lets a new item be accepted while a result waits.
// Reset is asynchronous; the level store is cleared at once by per-pixel valid bits.
module led_matrix_pwm_scan_top #(
    parameter int COLUMNS = lmps_pkg::COLUMNS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  lmps_pkg::in_item_t               item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output lmps_pkg::out_item_t              result,
    input  logic                             cfg_we,
    input  logic [lmps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lmps_pkg::ctrl_cmd_t cmd;
    lmps_pkg::dp_stat_t  stat;

    // Sequencer for accepts and tick stages.
    lmps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_op    (item.operation),
        .stat       (stat),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // Store, counters, threshold arithmetic and output register.
    lmps_dp #(
        .COLUMNS (COLUMNS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: src/lmps_checker.sv
module lmps_checker #(
    parameter int COLUMNS = lmps_pkg::COLUMNS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_stall,
    input  lmps_pkg::in_item_t               item,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  lmps_pkg::out_item_t              result
);

    logic write_xfer;
    logic tick_xfer;

    assign write_xfer = item_valid && !item_stall && (item.operation == lmps_pkg::OP_WRITE);
    assign tick_xfer  = item_valid && !item_stall && (item.operation == lmps_pkg::OP_TICK);

    // A stalled result stays valid and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A pixel write never blocks the next item.
    a_write_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        write_xfer |=> !item_stall)
        else $error("stall after pixel write");

    // A tick occupies the block for its compute stages.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick_xfer |=> item_stall ##1 item_stall)
        else $error("input not held off during tick");

    // Frame end only appears on the last column.
    a_frame_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_end |-> result.column == 3'(COLUMNS - 1))
        else $error("frame end on wrong column");

endmodule

bind led_matrix_pwm_scan_top lmps_checker #(.COLUMNS(COLUMNS)) u_lmps_checker (.*);
